// ===== rtl/core/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the transfer chunk planner.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned REQ_BITS = 20;
  localparam int unsigned CHUNK_BITS = 18;
  localparam int unsigned LG_BITS = 4;

  localparam int unsigned PIO_MAX_BYTES_DEFAULT = 64;
  localparam int unsigned DMA_MAX_BYTES_DEFAULT = 262140;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Chunks emitted for one accepted word before the planner waits for the
  // next word to go on with the same request.
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [LG_BITS-1:0] LG_RESET = 4'd6;
  localparam logic [LG_BITS-1:0] LG_MIN = 4'd2;
  localparam logic [LG_BITS-1:0] LG_MAX = 4'd8;

  typedef enum logic [1:0] {
    CACHE_NONE       = 2'd0,
    CACHE_INVALIDATE = 2'd1,
    CACHE_CLEAN      = 2'd2
  } cache_action_t;

  typedef struct packed {
    logic                is_read;
    logic [ADDR_BITS-1:0] start_address;
    logic [REQ_BITS-1:0]  request_bytes;
  } req_t;

  typedef struct packed {
    logic                  use_pio;
    logic [ADDR_BITS-1:0]  chunk_address;
    logic [CHUNK_BITS-1:0] chunk_bytes;
    cache_action_t         cache_action;
    logic                  chunk_is_read;
    logic                  last;
  } chunk_t;

  typedef struct packed {
    logic                 is_read;
    logic [ADDR_BITS-1:0] start_address;
    logic [REQ_BITS-1:0]  request_bytes;
    logic                 is_empty;
  } scp_entry_t;

endpackage

// ===== rtl/core/scp_front.sv =====
// ----------------------------------------------------------------------------
// scp_front
// Input stage: registers a request word and marks zero-length requests.
// ----------------------------------------------------------------------------
module scp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scp_pkg::req_t       in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output scp_pkg::scp_entry_t push_entry
);

  logic                stage_valid;
  scp_pkg::scp_entry_t stage_entry;

  assign in_ready   = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_entry = stage_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_entry.is_read       <= in_data.is_read;
      stage_entry.start_address <= in_data.start_address;
      stage_entry.request_bytes <= in_data.request_bytes;
      stage_entry.is_empty      <= (in_data.request_bytes == '0);
    end
  end

endmodule

// ===== rtl/core/scp_queue.sv =====
// ----------------------------------------------------------------------------
// scp_queue
// Short FIFO of classified request words between front and back.
// ----------------------------------------------------------------------------
module scp_queue #(
  parameter int unsigned DEPTH = scp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  scp_pkg::scp_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop,
  output scp_pkg::scp_entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scp_pkg::scp_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/scp_back.sv =====
// ----------------------------------------------------------------------------
// scp_back
// Chunk sequencer: walks one request, one chunk per cycle unless stalled or held.
// ----------------------------------------------------------------------------
module scp_back #(
  parameter int unsigned PIO_MAX_BYTES = scp_pkg::PIO_MAX_BYTES_DEFAULT,
  parameter int unsigned DMA_MAX_BYTES = scp_pkg::DMA_MAX_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [scp_pkg::LG_BITS-1:0]    line_lg,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  scp_pkg::scp_entry_t            q_entry,
  output logic                           out_valid,
  input  logic                           out_ready,
  output scp_pkg::chunk_t                out_data
);

  localparam int unsigned AW = scp_pkg::ADDR_BITS;
  localparam int unsigned RW = scp_pkg::REQ_BITS;
  localparam int unsigned CNT_W = $clog2(scp_pkg::MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t           state;
  logic [RW-1:0]    remaining;
  logic [AW-1:0]    cur_addr;
  logic             cur_dir;
  logic [CNT_W-1:0] burst_cnt;

  logic [8:0]    line_len;
  logic [7:0]    line_mask;
  logic [7:0]    offs;
  logic          pio;
  logic [RW-1:0] line_gap;
  logic [RW-1:0] pio_span;
  logic [RW-1:0] pio_xfer;
  logic [RW-1:0] dma_span;
  logic [RW-1:0] dma_xfer;
  logic [RW-1:0] xfer;
  logic [RW-1:0] rem_after;
  logic          slot_free;

  always_comb begin
    line_len  = 9'd1 << line_lg;
    line_mask = 8'(line_len - 9'd1);
    offs      = cur_addr[7:0] & line_mask;
    pio       = (offs != '0) || (remaining < RW'(line_len));
    line_gap  = RW'(line_len - {1'b0, offs});
    // An aligned PIO chunk takes the whole short remainder, up to the PIO cap.
    if (offs != '0) begin
      pio_span = (line_gap < remaining) ? line_gap : remaining;
    end else begin
      pio_span = remaining;
    end
    pio_xfer  = (pio_span < RW'(PIO_MAX_BYTES)) ? pio_span : RW'(PIO_MAX_BYTES);
    dma_span  = (remaining < RW'(DMA_MAX_BYTES)) ? remaining : RW'(DMA_MAX_BYTES);
    dma_xfer  = dma_span & ~RW'(line_mask);
    xfer      = pio ? pio_xfer : dma_xfer;
    rem_after = remaining - xfer;
  end

  assign slot_free = !out_valid || out_ready;
  assign q_pop     = q_valid && ((state == ST_IDLE) || (state == ST_HOLD));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      burst_cnt <= '0;
    end else begin
      // In the run state the chunk path reloads the output register itself.
      if (out_valid && out_ready && (state != ST_RUN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid && !q_entry.is_empty) begin
            remaining <= q_entry.request_bytes;
            cur_addr  <= q_entry.start_address;
            cur_dir   <= q_entry.is_read;
            burst_cnt <= '0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            out_valid              <= 1'b1;
            out_data.use_pio       <= pio;
            out_data.chunk_address <= cur_addr;
            out_data.chunk_bytes   <= scp_pkg::CHUNK_BITS'(xfer);
            if (pio) begin
              out_data.cache_action <= scp_pkg::CACHE_NONE;
            end else if (cur_dir) begin
              out_data.cache_action <= scp_pkg::CACHE_INVALIDATE;
            end else begin
              out_data.cache_action <= scp_pkg::CACHE_CLEAN;
            end
            out_data.chunk_is_read <= cur_dir;
            out_data.last          <= (rem_after == '0);
            remaining              <= rem_after;
            cur_addr               <= cur_addr + AW'(xfer);
            burst_cnt              <= burst_cnt + 1'b1;
            if (rem_after == '0) begin
              state <= ST_IDLE;
            end else if (burst_cnt == CNT_W'(scp_pkg::MAX_RESULTS - 1)) begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          // The next word only resumes the pending request; its fields are dropped.
          if (q_valid) begin
            burst_cnt <= '0;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/spi_transfer_chunk_planner_unit.sv =====
// ----------------------------------------------------------------------------
// spi_transfer_chunk_planner_unit
// Splits a transfer request into PIO and DMA chunks with cache maintenance.
//
//   channel   direction  handshake            word
//   in        input      in_valid/in_ready    scp_pkg::req_t
//   out       output     out_valid/out_ready  scp_pkg::chunk_t
//   cfg       input      cfg_we               line_size_log2 (4 bits)
//
// The chunk sequencer loads a request from the queue and then emits its
// chunks one at a time through its single chunk datapath; a zero-length
// request is popped from the queue without producing a chunk.
// Reset is synchronous; the line size register resets to 6.
// A stalled output holds the sequencer while the input stage and queue
// keep taking requests until the queue and the input stage are full.
// ----------------------------------------------------------------------------
module spi_transfer_chunk_planner_unit #(
  parameter int unsigned PIO_MAX_BYTES = scp_pkg::PIO_MAX_BYTES_DEFAULT,
  parameter int unsigned DMA_MAX_BYTES = scp_pkg::DMA_MAX_BYTES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH   = scp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scp_pkg::LG_BITS-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  scp_pkg::req_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scp_pkg::chunk_t             out_data
);

  logic [scp_pkg::LG_BITS-1:0] line_size_log2;
  logic [scp_pkg::LG_BITS-1:0] line_lg;
  logic                        push_valid;
  logic                        push_ready;
  scp_pkg::scp_entry_t         push_entry;
  logic                        q_valid;
  logic                        q_pop;
  scp_pkg::scp_entry_t         q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size_log2 <= scp_pkg::LG_RESET;
    end else if (cfg_we) begin
      line_size_log2 <= cfg_wdata;
    end
  end

  always_comb begin
    if (line_size_log2 < scp_pkg::LG_MIN) begin
      line_lg = scp_pkg::LG_MIN;
    end else if (line_size_log2 > scp_pkg::LG_MAX) begin
      line_lg = scp_pkg::LG_MAX;
    end else begin
      line_lg = line_size_log2;
    end
  end

  scp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  scp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  scp_back #(
    .PIO_MAX_BYTES (PIO_MAX_BYTES),
    .DMA_MAX_BYTES (DMA_MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .line_lg   (line_lg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/scp_chunk_monitor.sv =====
// ----------------------------------------------------------------------------
// scp_chunk_monitor
// Watches the request, chunk and line size ports of the chunk planner. It
// keeps its own copy of the planner state, works out the chunks that each
// accepted request word must produce, and compares every chunk word that
// leaves the block field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module scp_chunk_monitor #(
  parameter int unsigned PIO_MAX = scp_pkg::PIO_MAX_BYTES_DEFAULT,
  parameter int unsigned DMA_MAX = scp_pkg::DMA_MAX_BYTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scp_pkg::LG_BITS-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  scp_pkg::req_t               in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  scp_pkg::chunk_t             out_data,
  output int                          errors,
  output int                          pending,
  output int                          requests,
  output int                          chunks
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [scp_pkg::LG_BITS-1:0]   line_lg;
  logic [scp_pkg::REQ_BITS-1:0]  plan_left;
  logic [scp_pkg::ADDR_BITS-1:0] plan_addr;
  logic                          plan_dir;
  logic                          plan_busy;
  scp_pkg::chunk_t               due_chunks[$];

  // Splits the current request into chunks; a request that needs more than
  // MAX_RESULTS chunks carries over and swallows the following words.
  task automatic plan_chunks(input scp_pkg::req_t req);
    logic [scp_pkg::LG_BITS-1:0] lg;
    longint unsigned             line;
    longint unsigned             offs;
    longint unsigned             xfer;
    int                          n;
    bit                          pio;
    scp_pkg::chunk_t             c;
    lg = line_lg;
    if (lg < scp_pkg::LG_MIN) lg = scp_pkg::LG_MIN;
    if (lg > scp_pkg::LG_MAX) lg = scp_pkg::LG_MAX;
    line = 64'd1 << lg;
    if (!plan_busy) begin
      plan_dir = req.is_read;
      plan_addr = req.start_address;
      plan_left = req.request_bytes;
      if (plan_left == 0) return;
      plan_busy = 1'b1;
    end
    n = 0;
    while (plan_left != 0 && n < scp_pkg::MAX_RESULTS) begin
      offs = 64'(plan_addr) & (line - 1);
      pio = (offs != 0) || (64'(plan_left) < line);
      if (pio) begin
        xfer = (offs != 0) ? line - offs : 64'd0;
        if (xfer > 64'(plan_left)) xfer = 64'(plan_left);
        if (xfer == 0) xfer = 64'(plan_left);
        if (xfer > 64'(PIO_MAX)) xfer = 64'(PIO_MAX);
      end else begin
        xfer = 64'(plan_left);
        if (xfer > 64'(DMA_MAX)) xfer = 64'(DMA_MAX);
        xfer &= ~(line - 1);
      end
      c.use_pio = pio;
      c.chunk_address = plan_addr;
      c.chunk_bytes = xfer[scp_pkg::CHUNK_BITS-1:0];
      if (pio) c.cache_action = scp_pkg::CACHE_NONE;
      else if (plan_dir) c.cache_action = scp_pkg::CACHE_INVALIDATE;
      else c.cache_action = scp_pkg::CACHE_CLEAN;
      c.chunk_is_read = plan_dir;
      plan_left = plan_left - xfer[scp_pkg::REQ_BITS-1:0];
      plan_addr = plan_addr + xfer[scp_pkg::ADDR_BITS-1:0];
      c.last = (plan_left == 0);
      due_chunks.push_back(c);
      n++;
    end
    if (plan_left == 0) plan_busy = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    errors++;
    if (errors <= 10)
      $display("Chunk %0d: %s expected 0x%0h, got 0x%0h", chunks, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    scp_pkg::chunk_t want;
    if (rst) begin
      line_lg = scp_pkg::LG_RESET;
      plan_left = '0;
      plan_addr = '0;
      plan_dir = 1'b0;
      plan_busy = 1'b0;
      due_chunks.delete();
    end else begin
      if (cfg_we) line_lg = cfg_wdata;
      if (in_valid && in_ready) begin
        requests++;
        plan_chunks(in_data);
      end
      if (out_valid && out_ready) begin
        chunks++;
        if (due_chunks.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Chunk %0d: no chunk outstanding, got address 0x%0h bytes %0d",
                     chunks, out_data.chunk_address, out_data.chunk_bytes);
        end else begin
          want = due_chunks.pop_front();
          if (out_data.use_pio !== want.use_pio)
            note_mismatch("use_pio", 64'(want.use_pio), 64'(out_data.use_pio));
          if (out_data.chunk_address !== want.chunk_address)
            note_mismatch("chunk_address", 64'(want.chunk_address),
                          64'(out_data.chunk_address));
          if (out_data.chunk_bytes !== want.chunk_bytes)
            note_mismatch("chunk_bytes", 64'(want.chunk_bytes), 64'(out_data.chunk_bytes));
          if (out_data.cache_action !== want.cache_action)
            note_mismatch("cache_action", 64'(want.cache_action),
                          64'(out_data.cache_action));
          if (out_data.chunk_is_read !== want.chunk_is_read)
            note_mismatch("chunk_is_read", 64'(want.chunk_is_read),
                          64'(out_data.chunk_is_read));
          if (out_data.last !== want.last)
            note_mismatch("last", 64'(want.last), 64'(out_data.last));
        end
      end
    end
    pending = due_chunks.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the transfer chunk planner. A directed set covers
// empty, maximal, wrapping and unaligned requests at several line sizes;
// random phases then run at further line sizes with random idling on both
// channels, a long output hold and a full drain. The monitor does the checks.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_WORDS = 17;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [scp_pkg::LG_BITS-1:0] cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  scp_pkg::req_t               in_data;
  logic                        out_valid;
  logic                        out_ready;
  scp_pkg::chunk_t             out_data;

  int errors;
  int pending;
  int requests;
  int chunks;
  int quiet_cycles;
  int hold_asks;
  int settings_used;
  int directed_words;
  bit idle_on;

  spi_transfer_chunk_planner_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  scp_chunk_monitor u_monitor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .requests  (requests),
    .chunks    (chunks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic scp_pkg::req_t mk_req(input logic rd,
                                           input logic [scp_pkg::ADDR_BITS-1:0] addr,
                                           input logic [scp_pkg::REQ_BITS-1:0] nbytes);
    scp_pkg::req_t r;
    r.is_read = rd;
    r.start_address = addr;
    r.request_bytes = nbytes;
    return r;
  endfunction

  function automatic scp_pkg::req_t random_req();
    scp_pkg::req_t r;
    int            pick;
    r.is_read = 1'($urandom_range(0, 1));
    r.start_address = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 25) r.start_address[7:0] = '0;
    else if (pick < 33) r.start_address[31:12] = '1;
    pick = $urandom_range(0, 99);
    if (pick < 5) r.request_bytes = '0;
    else if (pick < 55) r.request_bytes = scp_pkg::REQ_BITS'($urandom_range(1, 600));
    else if (pick < 80) r.request_bytes = scp_pkg::REQ_BITS'($urandom_range(601, 20000));
    else if (pick < 94) r.request_bytes = scp_pkg::REQ_BITS'($urandom_range(20001, 300000));
    else r.request_bytes = scp_pkg::REQ_BITS'($urandom());
    return r;
  endfunction

  task automatic send_req(input scp_pkg::req_t req);
    int gap;
    gap = pick_gap();
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // Empty requests leave no chunk behind, so let the pipeline settle as well.
  task automatic set_line_size(input logic [scp_pkg::LG_BITS-1:0] lg);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = lg;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  initial begin : receiver
    int stall;
    int hold_left;
    int holds_seen;
    stall = 0;
    hold_left = 0;
    holds_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (rst) begin
        out_ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        out_ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d chunks outstanding",
                 STALL_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [scp_pkg::LG_BITS-1:0] phase_lg[PHASES];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    hold_asks = 0;
    settings_used = 1;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words at the reset line size of 64 bytes.
    send_req(mk_req(1'b1, 32'h0000_0000, 20'd0));
    send_req(mk_req(1'b0, 32'hFFFF_FFFF, 20'd0));
    send_req(mk_req(1'b1, 32'h0000_0000, 20'hFFFFF));
    send_req(mk_req(1'b0, 32'h0000_0000, 20'hFFFFF));
    send_req(mk_req(1'b0, 32'hFFFF_FFFF, 20'd300));
    send_req(mk_req(1'b1, 32'hFFFF_FFC0, 20'd256));
    send_req(mk_req(1'b1, 32'h0000_1003, 20'd10));
    send_req(mk_req(1'b0, 32'h0000_0040, 20'd5));
    send_req(mk_req(1'b0, 32'h0000_0080, 20'd64));
    send_req(mk_req(1'b1, 32'h0000_1001, 20'd1000));
    send_req(mk_req(1'b0, 32'h0000_0000, 20'd1));
    send_req(mk_req(1'b1, 32'hAAAA_AAAA, 20'h55555));
    send_req(mk_req(1'b0, 32'h5555_5555, 20'hAAAAA));
    send_req(mk_req(1'b1, 32'h0000_0100, 20'd262144));
    // A 256-byte line makes the unaligned head split at the PIO cap.
    set_line_size(scp_pkg::LG_MAX);
    send_req(mk_req(1'b0, 32'h0000_0001, 20'd1000));
    send_req(mk_req(1'b1, 32'h0000_0000, 20'd262143));
    // Codes outside the legal range clamp to the nearest legal line size.
    set_line_size(4'd0);
    send_req(mk_req(1'b1, 32'h0000_0003, 20'hFFFFF));
    send_req(mk_req(1'b0, 32'h0000_0002, 20'd3));
    set_line_size(4'd15);
    send_req(mk_req(1'b0, 32'hFFFF_FF01, 20'd600));
    send_req(mk_req(1'b1, 32'h0000_0000, 20'd255));
    directed_words = requests;

    phase_lg = '{scp_pkg::LG_MIN, scp_pkg::LG_MAX, 4'd4, 4'd15, 4'd0,
                 scp_pkg::LG_BITS'($urandom_range(3, 7))};
    for (int p = 0; p < PHASES; p++) begin
      set_line_size(phase_lg[p]);
      idle_on = (p != 0);
      // The sender keeps offering words while the output is held off.
      if (p == 1) hold_asks++;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 2 && i == PHASE_WORDS / 2) wait_drained();
        send_req(random_req());
      end
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d requests (%0d directed) split into %0d chunks over %0d line sizes.",
             requests, directed_words, chunks, settings_used);
    $display("Included a %0d-cycle output hold under input pressure and a mid-phase drain.",
             LONG_HOLD);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches found", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
